FILE: hdl/ecal_pkg.sv
// ----------------------------------------------------------------------------
// ecal_pkg
// Types, constants and helpers shared by the epoch-to-calendar blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package ecal_pkg;

    localparam int WORD_W  = 32;
    localparam int DAYS_W  = 16;
    localparam int YEAR_W  = 12;

    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
    localparam logic [DAYS_W-1:0] BASE_WDAY = 16'd4;   // 1970-01-01 was a Thursday

    localparam logic [5:0] DIV_60 = 6'd60;
    localparam logic [5:0] DIV_24 = 6'd24;
    localparam logic [5:0] DIV_7  = 6'd7;

    // divide by 2^k * d as ((x >> k) * ceil(2^s / d)) >> s, exact for x >> k below 2^30
    localparam int MUL_A_W = 30;
    localparam int RECIP_W = 31;
    localparam int PROD_W  = MUL_A_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_15 = 31'd1145324613;   // ceil(2^34 / 15)
    localparam logic [RECIP_W-1:0] RECIP_3  = 31'd1431655766;   // ceil(2^32 / 3)
    localparam logic [RECIP_W-1:0] RECIP_7  = 31'd1227133514;   // ceil(2^33 / 7)
    localparam int SHIFT_15 = 34;
    localparam int SHIFT_3  = 32;
    localparam int SHIFT_7  = 33;

    localparam logic [8:0] YEAR_LEN      = 9'd365;
    localparam logic [8:0] LEAP_YEAR_LEN = 9'd366;
    localparam logic [3:0] MONTH_FEB     = 4'd1;
    localparam logic [3:0] MONTH_DEC     = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEC,
        S_MIN,
        S_HOUR,
        S_WDAY,
        S_YEAR,
        S_MONTH,
        S_EMIT
    } t_ecal_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_ecal_op;

    typedef enum logic [1:0] {
        DSEL_SEC,
        DSEL_MIN,
        DSEL_HOUR,
        DSEL_WDAY
    } t_ecal_dsel;

    typedef struct packed {
        t_ecal_op   op;
        t_ecal_dsel div_sel;
        logic       in_ready;
    } t_ecal_cmd;

    typedef struct packed {
        logic in_valid;
        logic div_last;
        logic year_done;
        logic month_done;
        logic out_free;
    } t_ecal_stat;

    // month length, month counted from 0
    function automatic logic [4:0] f_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd0:      len = 5'd31;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd2:      len = 5'd31;
            4'd3:      len = 5'd30;
            4'd4:      len = 5'd31;
            4'd5:      len = 5'd30;
            4'd6:      len = 5'd31;
            4'd7:      len = 5'd31;
            4'd8:      len = 5'd30;
            4'd9:      len = 5'd31;
            4'd10:     len = 5'd30;
            4'd11:     len = 5'd31;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ecal_if.sv
// ----------------------------------------------------------------------------
// ecal_if
// Valid/ready channels for the epoch word in and the calendar word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecal_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [11:0] year;

    modport source (output valid, output second, output minute, output hour,
                    output day_of_month, output weekday, output month, output year,
                    input ready);
    modport sink   (input valid, input second, input minute, input hour,
                    input day_of_month, input weekday, input month, input year,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/ecal_ctrl.sv
// ----------------------------------------------------------------------------
// ecal_ctrl
// Sequencer: divider passes, year walk, month walk, output load.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_ctrl
    import ecal_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_ecal_stat i_stat,
    output t_ecal_cmd  o_cmd
);

    t_ecal_state r_state;
    t_ecal_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_stat.in_valid)   n_state = S_SEC;
            S_SEC:   if (i_stat.div_last)   n_state = S_MIN;
            S_MIN:   if (i_stat.div_last)   n_state = S_HOUR;
            S_HOUR:  if (i_stat.div_last)   n_state = S_WDAY;
            S_WDAY:  if (i_stat.div_last)   n_state = S_YEAR;
            S_YEAR:  if (i_stat.year_done)  n_state = S_MONTH;
            S_MONTH: if (i_stat.month_done) n_state = S_EMIT;
            S_EMIT:  if (i_stat.out_free)   n_state = S_IDLE;
            default:                        n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.div_sel  = DSEL_SEC;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_rst_n;
                if (i_rst_n && i_stat.in_valid) o_cmd.op = OP_LOAD;
            end
            S_SEC: begin
                o_cmd.op      = OP_DIV;
                o_cmd.div_sel = DSEL_SEC;
            end
            S_MIN: begin
                o_cmd.op      = OP_DIV;
                o_cmd.div_sel = DSEL_MIN;
            end
            S_HOUR: begin
                o_cmd.op      = OP_DIV;
                o_cmd.div_sel = DSEL_HOUR;
            end
            S_WDAY: begin
                o_cmd.op      = OP_DIV;
                o_cmd.div_sel = DSEL_WDAY;
            end
            S_YEAR:  o_cmd.op = OP_YEAR;
            S_MONTH: o_cmd.op = OP_MONTH;
            S_EMIT:  if (i_stat.out_free) o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/ecal_dp.sv
// ----------------------------------------------------------------------------
// ecal_dp
// Datapath: reciprocal-multiply constant divider, year and month walkers,
// output word.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_dp
    import ecal_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_ecal_cmd  i_cmd,
    output t_ecal_stat o_stat,
    ecal_in_if.sink    i_epoch,
    ecal_out_if.source o_cal
);

    logic [WORD_W-1:0] r_work;
    logic [WORD_W-1:0] r_quo;
    logic              r_phase;
    logic [DAYS_W-1:0] r_days;
    logic [5:0]        r_sec;
    logic [5:0]        r_min;
    logic [4:0]        r_hour;
    logic [2:0]        r_wday;
    logic [YEAR_W-1:0] r_year;
    logic [3:0]        r_month;

    logic              r_out_valid;
    logic [5:0]        r_o_sec;
    logic [5:0]        r_o_min;
    logic [4:0]        r_o_hour;
    logic [4:0]        r_o_day;
    logic [2:0]        r_o_wday;
    logic [3:0]        r_o_month;
    logic [YEAR_W-1:0] r_o_year;

    logic [5:0]         divisor;
    logic [MUL_A_W-1:0] mul_a;
    logic [RECIP_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [WORD_W-1:0]  quo;
    logic [5:0]         rem;
    logic               leap;
    logic [8:0]         year_len;
    logic [4:0]         mon_len;
    logic               year_done;
    logic               month_done;
    logic               out_free;

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_SEC, DSEL_MIN: begin
                divisor = DIV_60;
                mul_a   = r_work[WORD_W-1:2];
                mul_b   = RECIP_15;
            end
            DSEL_HOUR: begin
                divisor = DIV_24;
                mul_a   = MUL_A_W'(r_work[WORD_W-1:3]);
                mul_b   = RECIP_3;
            end
            DSEL_WDAY: begin
                divisor = DIV_7;
                mul_a   = r_work[MUL_A_W-1:0];
                mul_b   = RECIP_7;
            end
            default: begin
                divisor = DIV_60;
                mul_a   = r_work[WORD_W-1:2];
                mul_b   = RECIP_15;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
        case (i_cmd.div_sel)
            DSEL_SEC, DSEL_MIN: quo = WORD_W'(prod[PROD_W-1:SHIFT_15]);
            DSEL_HOUR:          quo = WORD_W'(prod[PROD_W-1:SHIFT_3]);
            DSEL_WDAY:          quo = WORD_W'(prod[PROD_W-1:SHIFT_7]);
            default:            quo = WORD_W'(prod[PROD_W-1:SHIFT_15]);
        endcase
        // remainder is below 64, so the low six bits are enough
        rem = r_work[5:0] - 6'(r_quo[5:0] * divisor);

        leap       = (r_year[1:0] == 2'd0);
        year_len   = leap ? LEAP_YEAR_LEN : YEAR_LEN;
        mon_len    = f_month_len(r_month, leap);
        year_done  = (r_days < DAYS_W'(year_len));
        month_done = (r_month == MONTH_DEC) || (r_days < DAYS_W'(mon_len));
        out_free   = !r_out_valid || o_cal.ready;
    end

    assign o_stat.in_valid   = i_epoch.valid;
    assign o_stat.div_last   = r_phase;
    assign o_stat.year_done  = year_done;
    assign o_stat.month_done = month_done;
    assign o_stat.out_free   = out_free;

    assign i_epoch.ready = i_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_work  <= i_epoch.epoch_seconds;
                r_phase <= 1'b0;
            end
            OP_DIV: begin
                r_phase <= !r_phase;
                if (!r_phase) begin
                    r_quo <= quo;
                end else begin
                    case (i_cmd.div_sel)
                        DSEL_SEC: begin
                            r_sec  <= rem;
                            r_work <= r_quo;
                        end
                        DSEL_MIN: begin
                            r_min  <= rem;
                            r_work <= r_quo;
                        end
                        DSEL_HOUR: begin
                            r_hour <= rem[4:0];
                            r_days <= r_quo[DAYS_W-1:0];
                            r_work <= WORD_W'(r_quo[DAYS_W-1:0] + BASE_WDAY);
                        end
                        DSEL_WDAY: begin
                            r_wday  <= rem[2:0];
                            r_year  <= BASE_YEAR;
                            r_month <= '0;
                        end
                        default: r_work <= r_quo;
                    endcase
                end
            end
            OP_YEAR: begin
                if (!year_done) begin
                    r_days <= r_days - DAYS_W'(year_len);
                    r_year <= r_year + YEAR_W'(1);
                end
            end
            OP_MONTH: begin
                if (!month_done) begin
                    r_days  <= r_days - DAYS_W'(mon_len);
                    r_month <= r_month + 4'd1;
                end
            end
            OP_EMIT: begin
                r_o_sec   <= r_sec;
                r_o_min   <= r_min;
                r_o_hour  <= r_hour;
                r_o_day   <= r_days[4:0] + 5'd1;
                r_o_wday  <= r_wday;
                r_o_month <= r_month + 4'd1;
                r_o_year  <= r_year;
            end
            default: r_phase <= r_phase;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (o_cal.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_cal.valid        = r_out_valid;
    assign o_cal.second       = r_o_sec;
    assign o_cal.minute       = r_o_min;
    assign o_cal.hour         = r_o_hour;
    assign o_cal.day_of_month = r_o_day;
    assign o_cal.weekday      = r_o_wday;
    assign o_cal.month        = r_o_month;
    assign o_cal.year         = r_o_year;

endmodule

`default_nettype wire

FILE: hdl/epoch_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_unit
// Converts a 32-bit seconds-since-1970 count into time of day, weekday, date.
// ----------------------------------------------------------------------------
// One word is converted at a time. From the accepting edge to the output load,
// a reciprocal-multiply divider strips seconds, minutes, hours and weekday in
// four passes, each registering a quotient and then a remainder; then the year
// is walked one year per cycle from 1970 and the month one month per cycle.
// The longest conversion is for a date in December 2105. Leap years are every
// fourth year with no century rule, so 2100 is taken as a leap year. The result
// sits in an output register; the load waits while that register holds an
// unread word, and the next epoch word is taken the cycle after the load, even
// while the result waits to be read.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_to_calendar_unit
    import ecal_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    ecal_in_if.sink    i_epoch,
    ecal_out_if.source o_cal
);

    t_ecal_cmd  cmd;
    t_ecal_stat stat;

    ecal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ecal_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_epoch (i_epoch),
        .o_cal   (o_cal)
    );

endmodule

`default_nettype wire

FILE: verif/epoch_to_calendar_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_to_calendar_unit_tb
// Drives epoch words into the converter and scores every calendar word it
// returns, in order. A directed table covers the ends of the 32-bit range,
// day, month and year rollovers and the 2100 leap-year quirk. Random words
// follow, weighted toward day boundaries and the last years of the range.
// Both channels idle at random. Results are scored against an in-bench
// calendar model, or against values typed into the table where they are
// obvious.
// ----------------------------------------------------------------------------

module epoch_to_calendar_unit_tb
    import ecal_pkg::*;
();

    localparam int unsigned FIRST_YEAR   = 1970;
    localparam int unsigned FIRST_WDAY   = 4;
    localparam int unsigned FEBRUARY     = 1;
    localparam int unsigned DECEMBER     = 11;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int          RANDOM_WORDS = 1300;
    localparam int          SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [5:0]        second;
        logic [5:0]        minute;
        logic [4:0]        hour;
        logic [4:0]        day_of_month;
        logic [2:0]        weekday;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } t_cal_word;

    typedef struct packed {
        logic [WORD_W-1:0] epoch;
        logic              typed;
        t_cal_word         cal;
    } t_dir_row;

    typedef struct packed {
        logic [WORD_W-1:0] epoch;
        t_cal_word         cal;
    } t_pending;

    localparam int DIR_ROWS = 24;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{32'd0,          1'b1, '{6'd0,  6'd0,  5'd0,  5'd1, 3'd4, 4'd1, 12'd1970}},
        '{32'd59,         1'b1, '{6'd59, 6'd0,  5'd0,  5'd1, 3'd4, 4'd1, 12'd1970}},
        '{32'd60,         1'b0, '0},
        '{32'd3599,       1'b0, '0},
        '{32'd86399,      1'b1, '{6'd59, 6'd59, 5'd23, 5'd1, 3'd4, 4'd1, 12'd1970}},
        '{32'd86400,      1'b1, '{6'd0,  6'd0,  5'd0,  5'd2, 3'd5, 4'd1, 12'd1970}},
        '{32'd1,          1'b0, '0},
        '{32'd31535999,   1'b0, '0},
        '{32'd31536000,   1'b0, '0},
        '{32'd68169600,   1'b0, '0},
        '{32'd68256000,   1'b0, '0},
        '{32'd951782400,  1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd4102444800, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4107628800, 1'b0, '0},
        '{32'd4134067199, 1'b0, '0},
        '{32'd4134067200, 1'b0, '0},
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'h55555555,   1'b0, '0},
        '{32'hFFFFFFFE,   1'b0, '0},
        '{32'hFFFFFFFF,   1'b1, '{6'd15, 6'd28, 5'd6,  5'd6, 3'd0, 4'd2, 12'd2106}}
    };

    logic i_clk;
    logic i_rst_n;

    ecal_in_if  epoch_ch ();
    ecal_out_if cal_ch ();

    epoch_to_calendar_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_epoch (epoch_ch),
        .o_cal   (cal_ch)
    );

    t_pending cal_expected [$];
    int       mismatch_count = 0;
    bit       no_idle = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("epoch_to_calendar_unit_tb failed");
        $finish;
    end

    // divide-by-4 leap rule, no century exception
    function automatic t_cal_word to_calendar(input logic [WORD_W-1:0] epoch);
        t_cal_word   r;
        int unsigned t;
        int unsigned yr;
        int unsigned mon;
        int unsigned ylen;
        int unsigned mlen;
        t        = epoch;
        r.second = 6'(t % 60);
        t        = t / 60;
        r.minute = 6'(t % 60);
        t        = t / 60;
        r.hour   = 5'(t % 24);
        t        = t / 24;
        r.weekday = 3'((t + FIRST_WDAY) % 7);
        yr   = FIRST_YEAR;
        ylen = (yr % 4 == 0) ? 366 : 365;
        while (t >= ylen) begin
            t    = t - ylen;
            yr   = yr + 1;
            ylen = (yr % 4 == 0) ? 366 : 365;
        end
        mon = 0;
        while (mon < DECEMBER) begin
            mlen = MONTH_DAYS[mon];
            if (mon == FEBRUARY && yr % 4 == 0) begin
                mlen = 29;
            end
            if (t < mlen) begin
                break;
            end
            t   = t - mlen;
            mon = mon + 1;
        end
        r.day_of_month = 5'(t + 1);
        r.month        = 4'(mon + 1);
        r.year         = YEAR_W'(yr);
        return r;
    endfunction

    task automatic send_epoch(input logic [WORD_W-1:0] epoch, input t_cal_word cal);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            epoch_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        epoch_ch.valid         <= 1'b1;
        epoch_ch.epoch_seconds <= epoch;
        do @(posedge i_clk); while (!(epoch_ch.valid && epoch_ch.ready));
        cal_expected.push_back('{epoch, cal});
    endtask

    task automatic drain_results();
        epoch_ch.valid <= 1'b0;
        while (cal_expected.size() != 0) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int        stall;
        t_cal_word got;
        t_pending  want;
        cal_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                cal_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            cal_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(cal_ch.valid && cal_ch.ready));
            got = {cal_ch.second, cal_ch.minute, cal_ch.hour, cal_ch.day_of_month,
                   cal_ch.weekday, cal_ch.month, cal_ch.year};
            if (cal_expected.size() == 0) begin
                $display("%0t: unexpected calendar word %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                         $time, got.year, got.month, got.day_of_month,
                         got.hour, got.minute, got.second, got.weekday);
                mismatch_count++;
            end else begin
                want = cal_expected.pop_front();
                if (got !== want.cal) begin
                    $display("%0t: epoch %0d expected %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                             $time, want.epoch,
                             want.cal.year, want.cal.month, want.cal.day_of_month,
                             want.cal.hour, want.cal.minute, want.cal.second,
                             want.cal.weekday);
                    $display("%0t: epoch %0d actual   %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                             $time, want.epoch,
                             got.year, got.month, got.day_of_month,
                             got.hour, got.minute, got.second, got.weekday);
                    mismatch_count++;
                end
            end
        end
    end

    // epoch side
    initial begin
        int                k;
        logic [WORD_W-1:0] w;
        epoch_ch.valid         = 1'b0;
        epoch_ch.epoch_seconds = '0;
        i_rst_n                = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            send_epoch(DIRECTED[k].epoch,
                       DIRECTED[k].typed ? DIRECTED[k].cal : to_calendar(DIRECTED[k].epoch));
        end
        drain_results();

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 500) begin
                no_idle = 1'b1;
            end
            if (k == 650) begin
                no_idle = 1'b0;
            end
            if (k == 900) begin
                drain_results();
            end
            case ($urandom_range(0, 3))
                0, 1: w = $urandom;
                // whole days, first or last second
                2: w = $urandom_range(0, 49709) * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
                // last decade of the range, around the 2100 quirk
                default: w = 32'hF000_0000 | $urandom;
            endcase
            send_epoch(w, to_calendar(w));
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && cal_expected.size() == 0) begin
            $display("epoch_to_calendar_unit_tb passed");
        end else begin
            $display("epoch_to_calendar_unit_tb failed");
        end
        $finish;
    end

endmodule
